FILE: rtl/assert_macros.svh
// assertion macros included by the stepper top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is low
`define CBPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbps assertion failed");
// clocked check, active during reset too
`define CBPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cbps assertion failed");
`else
`define CBPS_ASSERT(lbl, clk, rst_n, prop)
`define CBPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/cbps_pkg.sv
// constants and codes of the cubic bezier path stepper
package cbps_pkg;

    localparam int unsigned CoordBits = 16;
    localparam int unsigned FracBits  = 16;
    localparam int unsigned TBits     = FracBits + 1;
    localparam int unsigned LenBits   = 19;
    localparam int unsigned ProdBits  = 3 * FracBits + CoordBits + 2;

    localparam logic [TBits-1:0]    OneT      = TBits'(1) << FracBits;
    localparam logic [ProdBits-1:0] RoundHalf = ProdBits'(1) << (3 * FracBits - 1);

    // item opcodes
    localparam logic OPC_ADVANCE = 1'b0;
    localparam logic OPC_SET     = 1'b1;

    // register indexes
    localparam logic [2:0] REG_POINT0 = 3'd0;
    localparam logic [2:0] REG_POINT1 = 3'd1;
    localparam logic [2:0] REG_POINT2 = 3'd2;
    localparam logic [2:0] REG_POINT3 = 3'd3;
    localparam logic [2:0] REG_SPEED  = 3'd4;

endpackage

FILE: rtl/cubic_bezier_path_stepper_unit.sv
// top level of the cubic bezier path stepper
// Moves a point along a 2-D cubic bezier curve given by four control points (x in the upper,
// y in the lower half of each register) and a speed, all written over the apb port. Every
// write to a point or the speed register starts a recompute of the control-polygon length
// (three euclidean segment lengths, each rounded, summed); no item is taken meanwhile. A set
// item (tuser = 1) loads the curve parameter, saturated at 1.0, and gives no result. An
// advance item (tuser = 0) is dropped once the parameter is at 1.0; otherwise it adds
// floor(elapsed_time * speed / length) to the parameter, clamps at 1.0 (a zero length jumps to
// 1.0), evaluates the bernstein form and returns the rounded point, with tlast set when the
// parameter sits at 1.0. The multiplies, the divide, the square root and the length and
// parameter sums go through one shared 66-bit adder under a small sequencer: bit-serial
// multiplies (one multiplier bit per step), a 32-step restoring divide and a 17-step square
// root. The block takes one item at a time and holds the result until it is taken.
`include "assert_macros.svh"

module cubic_bezier_path_stepper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // elapsed_time [15:0], new_parameter [32:16], zero pad
    input  logic [0:0]  i_s_tuser,   // opcode [0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // pos_x [15:0], pos_y [31:16]
    output logic        o_m_tlast,   // reached_end
    // configuration port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int unsigned PB = cbps_pkg::ProdBits;
    localparam int unsigned TB = cbps_pkg::TBits;
    localparam int unsigned LB = cbps_pkg::LenBits;
    localparam int unsigned CB = cbps_pkg::CoordBits;
    localparam int unsigned FB = cbps_pkg::FracBits;
    localparam int unsigned WB = 3 * FB + 1;   // bernstein weight width

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MLOAD  = 4'd1;
    localparam logic [3:0] S_MUL    = 4'd2;
    localparam logic [3:0] S_MSTORE = 4'd3;
    localparam logic [3:0] S_SQRT   = 4'd4;
    localparam logic [3:0] S_SRND   = 4'd5;
    localparam logic [3:0] S_SACC   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_TUPD   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // multiply program, run in order from OP_UU to OP_Y3
    localparam logic [4:0] OP_SQX  = 5'd0;
    localparam logic [4:0] OP_SQY  = 5'd1;
    localparam logic [4:0] OP_STEP = 5'd2;
    localparam logic [4:0] OP_UU   = 5'd3;
    localparam logic [4:0] OP_TT   = 5'd4;
    localparam logic [4:0] OP_U2U  = 5'd5;
    localparam logic [4:0] OP_T2T  = 5'd6;
    localparam logic [4:0] OP_U2T  = 5'd7;
    localparam logic [4:0] OP_W1   = 5'd8;
    localparam logic [4:0] OP_T2U  = 5'd9;
    localparam logic [4:0] OP_W2   = 5'd10;
    localparam logic [4:0] OP_X0   = 5'd11;
    localparam logic [4:0] OP_X1   = 5'd12;
    localparam logic [4:0] OP_X2   = 5'd13;
    localparam logic [4:0] OP_X3   = 5'd14;
    localparam logic [4:0] OP_Y0   = 5'd15;
    localparam logic [4:0] OP_Y1   = 5'd16;
    localparam logic [4:0] OP_Y2   = 5'd17;
    localparam logic [4:0] OP_Y3   = 5'd18;

    logic [3:0]     r_state;
    logic [4:0]     r_op;
    logic [1:0]     r_seg;
    logic [4:0]     r_cnt;
    logic [31:0]    r_pt [4];
    logic [15:0]    r_speed;
    logic [TB-1:0]  r_t;
    logic [LB-1:0]  r_len;
    logic [15:0]    r_el;
    // multiply unit
    logic [PB-1:0]  r_ma;
    logic [PB-1:0]  r_mp;
    logic [TB-1:0]  r_mb;
    // bernstein terms
    logic [2*TB-1:0] r_u2;
    logic [2*TB-1:0] r_t2;
    logic [WB-1:0]  r_tmp;
    logic [WB-1:0]  r_w [4];
    // square root
    logic [2*TB-1:0] r_sn;
    logic [19:0]    r_srem;
    logic [TB-1:0]  r_root;
    logic           r_inc;
    // divide
    logic [31:0]    r_dq;
    logic [LB-1:0]  r_drem;
    // result
    logic [CB-1:0]  r_pos_x;
    logic [CB-1:0]  r_pos_y;
    logic           r_end;

    // shared adder / subtractor
    logic [PB-1:0]  sh_a;
    logic [PB-1:0]  sh_b;
    logic           sh_sub;
    logic           sh_cin;
    logic [PB:0]    sh_res;

    logic           s_acc;
    logic           s_set;
    logic           cfg_wr;
    logic [TB-1:0]  in_newp;
    logic [TB-1:0]  t_u;
    logic [31:0]    seg_pa;
    logic [31:0]    seg_pb;
    logic signed [CB:0] seg_dx;
    logic signed [CB:0] seg_dy;
    logic [TB-1:0]  seg_ax;
    logic [TB-1:0]  seg_ay;
    logic [21:0]    sq_trial;
    logic [LB:0]    dv_trial;
    logic           ev_is_y;
    logic [1:0]     ev_k;
    logic [31:0]    ev_pt;
    logic [CB-1:0]  ev_c;
    logic [PB-1:0]  ld_a;
    logic [TB-1:0]  ld_b;
    logic           ld_keep;
    logic [PB-1:0]  ld_p;

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign s_set   = s_acc && (i_s_tuser[0] == cbps_pkg::OPC_SET);
    assign cfg_wr  = i_psel && i_penable && i_pwrite && o_pready;
    assign in_newp = i_s_tdata[32:16];
    assign t_u     = TB'(cbps_pkg::OneT - r_t);

    assign sh_res = {1'b0, sh_a} + {1'b0, (sh_sub ? ~sh_b : sh_b)} + {{PB{1'b0}}, sh_cin};

    // control-polygon segment being measured
    always_comb begin
        unique case (r_seg)
            2'd0: begin
                seg_pa = r_pt[0];
                seg_pb = r_pt[1];
            end
            2'd1: begin
                seg_pa = r_pt[1];
                seg_pb = r_pt[2];
            end
            default: begin
                seg_pa = r_pt[2];
                seg_pb = r_pt[3];
            end
        endcase
    end

    assign seg_dx = $signed({seg_pa[31], seg_pa[31:16]}) - $signed({seg_pb[31], seg_pb[31:16]});
    assign seg_dy = $signed({seg_pa[15], seg_pa[15:0]}) - $signed({seg_pb[15], seg_pb[15:0]});
    assign seg_ax = seg_dx[CB] ? TB'(-seg_dx) : TB'(seg_dx);
    assign seg_ay = seg_dy[CB] ? TB'(-seg_dy) : TB'(seg_dy);

    assign sq_trial = {r_srem, r_sn[2*TB-1:2*TB-2]};
    assign dv_trial = {r_drem, r_dq[31]};

    // weight times biased coordinate, control point picked by program step
    assign ev_is_y = (r_op >= OP_Y0);
    assign ev_k    = 2'(r_op - (ev_is_y ? OP_Y0 : OP_X0));
    assign ev_pt   = r_pt[ev_k];
    assign ev_c    = ev_is_y ? {~ev_pt[15], ev_pt[14:0]} : {~ev_pt[31], ev_pt[30:16]};

    // operands of each multiply step
    always_comb begin
        ld_a    = '0;
        ld_b    = '0;
        ld_keep = 1'b0;
        ld_p    = '0;
        unique case (r_op) inside
            OP_SQX: begin
                ld_a = PB'(seg_ax);
                ld_b = seg_ax;
            end
            OP_SQY: begin
                ld_a    = PB'(seg_ay);
                ld_b    = seg_ay;
                ld_keep = 1'b1;
            end
            OP_STEP: begin
                ld_a = PB'(r_el);
                ld_b = TB'(r_speed);
            end
            OP_UU: begin
                ld_a = PB'(t_u);
                ld_b = t_u;
            end
            OP_TT: begin
                ld_a = PB'(r_t);
                ld_b = r_t;
            end
            OP_U2U: begin
                ld_a = PB'(r_u2);
                ld_b = t_u;
            end
            OP_T2T: begin
                ld_a = PB'(r_t2);
                ld_b = r_t;
            end
            OP_U2T: begin
                ld_a = PB'(r_u2);
                ld_b = r_t;
            end
            OP_T2U: begin
                ld_a = PB'(r_t2);
                ld_b = t_u;
            end
            OP_W1, OP_W2: begin
                ld_a = PB'(r_tmp);
                ld_b = TB'(3);
            end
            OP_X0, OP_X1, OP_X2, OP_X3, OP_Y0, OP_Y1, OP_Y2, OP_Y3: begin
                ld_a    = PB'(r_w[ev_k]);
                ld_b    = TB'(ev_c);
                ld_p    = cbps_pkg::RoundHalf;
                ld_keep = (r_op != OP_X0) && (r_op != OP_Y0);
            end
            default: begin
                ld_a = '0;
            end
        endcase
    end

    // adder operand routing
    always_comb begin
        sh_a   = '0;
        sh_b   = '0;
        sh_sub = 1'b0;
        sh_cin = 1'b0;
        unique case (r_state)
            S_MUL: begin
                sh_a = r_mp;
                sh_b = r_ma;
            end
            S_SQRT: begin
                sh_a   = PB'(sq_trial);
                sh_b   = PB'({r_root, 2'b01});
                sh_sub = 1'b1;
                sh_cin = 1'b1;
            end
            S_SRND: begin
                // carry clear means root < remainder, round up
                sh_a   = PB'(r_root);
                sh_b   = PB'(r_srem);
                sh_sub = 1'b1;
                sh_cin = 1'b1;
            end
            S_SACC: begin
                sh_a   = PB'(r_len);
                sh_b   = PB'(r_root);
                sh_cin = r_inc;
            end
            S_DIV: begin
                sh_a   = PB'(dv_trial);
                sh_b   = PB'(r_len);
                sh_sub = 1'b1;
                sh_cin = 1'b1;
            end
            S_TUPD: begin
                sh_a = PB'(r_dq);
                sh_b = PB'(r_t);
            end
            default: begin
                sh_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_len   <= '0;
            r_speed <= '0;
            r_pt[0] <= '0;
            r_pt[1] <= '0;
            r_pt[2] <= '0;
            r_pt[3] <= '0;
            r_op    <= OP_SQX;
            r_seg   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_tuser[0] == cbps_pkg::OPC_SET) begin
                            r_t <= (in_newp > cbps_pkg::OneT) ? cbps_pkg::OneT : in_newp;
                        end else if (!r_t[FB]) begin
                            r_el    <= i_s_tdata[15:0];
                            r_state <= S_MLOAD;
                            if (r_len == '0) begin
                                // degenerate curve, jump to the end point
                                r_t  <= cbps_pkg::OneT;
                                r_op <= OP_UU;
                            end else begin
                                r_op <= OP_STEP;
                            end
                        end
                    end
                end
                S_MLOAD: begin
                    r_ma    <= ld_a;
                    r_mb    <= ld_b;
                    r_mp    <= ld_keep ? r_mp : ld_p;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // one multiplier bit per cycle, stop once no bits are left
                    if (r_mb == '0) begin
                        r_state <= S_MSTORE;
                    end else begin
                        if (r_mb[0]) begin
                            r_mp <= sh_res[PB-1:0];
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                S_MSTORE: begin
                    r_op    <= r_op + 5'd1;
                    r_state <= S_MLOAD;
                    unique case (r_op) inside
                        OP_SQY: begin
                            r_sn    <= r_mp[2*TB-1:0];
                            r_srem  <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_SQRT;
                        end
                        OP_STEP: begin
                            r_dq    <= r_mp[31:0];
                            r_drem  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                        OP_UU:  r_u2  <= r_mp[2*TB-1:0];
                        OP_TT:  r_t2  <= r_mp[2*TB-1:0];
                        OP_U2U: r_w[0] <= r_mp[WB-1:0];
                        OP_T2T: r_w[3] <= r_mp[WB-1:0];
                        OP_U2T, OP_T2U: r_tmp <= r_mp[WB-1:0];
                        OP_W1:  r_w[1] <= r_mp[WB-1:0];
                        OP_W2:  r_w[2] <= r_mp[WB-1:0];
                        OP_X3: begin
                            r_pos_x <= {~r_mp[3*FB+CB-1], r_mp[3*FB+CB-2:3*FB]};
                        end
                        OP_Y3: begin
                            r_pos_y <= {~r_mp[3*FB+CB-1], r_mp[3*FB+CB-2:3*FB]};
                            r_end   <= r_t[FB];
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_cnt <= r_cnt;
                        end
                    endcase
                end
                S_SQRT: begin
                    r_srem  <= sh_res[PB] ? sh_res[19:0] : sq_trial[19:0];
                    r_root  <= {r_root[TB-2:0], sh_res[PB]};
                    r_sn    <= r_sn << 2;
                    r_cnt   <= r_cnt + 5'd1;
                    if (r_cnt == 5'(TB - 1)) begin
                        r_state <= S_SRND;
                    end
                end
                S_SRND: begin
                    r_inc   <= !sh_res[PB];
                    r_state <= S_SACC;
                end
                S_SACC: begin
                    r_len <= sh_res[LB-1:0];
                    if (r_seg == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_seg   <= r_seg + 2'd1;
                        r_op    <= OP_SQX;
                        r_state <= S_MLOAD;
                    end
                end
                S_DIV: begin
                    r_drem <= sh_res[PB] ? sh_res[LB-1:0] : dv_trial[LB-1:0];
                    r_dq   <= {r_dq[30:0], sh_res[PB]};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_TUPD;
                    end
                end
                S_TUPD: begin
                    r_t     <= (sh_res[32:0] > 33'(cbps_pkg::OneT)) ? cbps_pkg::OneT
                                                                   : sh_res[TB-1:0];
                    r_op    <= OP_UU;
                    r_state <= S_MLOAD;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // a write to a point or the speed register restarts the length recompute
            if (cfg_wr && (i_paddr[4:2] <= cbps_pkg::REG_SPEED)) begin
                unique case (i_paddr[4:2])
                    cbps_pkg::REG_POINT0: r_pt[0] <= i_pwdata;
                    cbps_pkg::REG_POINT1: r_pt[1] <= i_pwdata;
                    cbps_pkg::REG_POINT2: r_pt[2] <= i_pwdata;
                    cbps_pkg::REG_POINT3: r_pt[3] <= i_pwdata;
                    default:              r_speed <= i_pwdata[15:0];
                endcase
                r_len   <= '0;
                r_seg   <= '0;
                r_op    <= OP_SQX;
                r_state <= S_MLOAD;
            end
        end
    end

    // register readback
    always_comb begin
        unique case (i_paddr[4:2])
            cbps_pkg::REG_POINT0: o_prdata = r_pt[0];
            cbps_pkg::REG_POINT1: o_prdata = r_pt[1];
            cbps_pkg::REG_POINT2: o_prdata = r_pt[2];
            cbps_pkg::REG_POINT3: o_prdata = r_pt[3];
            cbps_pkg::REG_SPEED:  o_prdata = {16'd0, r_speed};
            default:              o_prdata = '0;
        endcase
    end

    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {r_pos_y, r_pos_x};
    assign o_m_tlast  = r_end;

    // a held result blocks new items
    `CBPS_ASSERT(a_busy_excl, i_clk, i_rst_n, o_m_tvalid |-> !o_s_tready)
    // end flag agrees with the stored parameter while shown
    `CBPS_ASSERT(a_end_flag, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tlast == r_t[FB]))
    // the divider never runs on a zero length
    `CBPS_ASSERT(a_div_len, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_len != '0))
    // a set item never leaves the parameter above one
    `CBPS_ASSERT(a_set_sat, i_clk, i_rst_n, s_set |=> (r_t <= cbps_pkg::OneT))
    // no result straight after reset
    `CBPS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_tvalid)

endmodule
